>>> sv/fblrd_pkg.sv
// Shared types, constants and codes of the framebuffer line and rectangle drawing engine.
`default_nettype none
package fblrd_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CW      = 20;  // internal signed coordinate width
  localparam int IN_W    = 16;  // input coordinate width
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 9;
  localparam int XY_W    = 12;  // enough for any pixel index below 4096
  localparam int DIV_NW  = 36;  // divider numerator width
  localparam int DIV_DW  = 16;  // divider denominator width
  localparam int SL_W    = 18;  // slope operand width

  localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

  typedef logic signed [CW-1:0] coord_t;
  localparam coord_t C_ZERO = 20'sd0;
  localparam coord_t C_ONE  = 20'sd1;

  localparam logic CFG_CANVAS_W = 1'b0;
  localparam logic CFG_CANVAS_H = 1'b1;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_LINE  = 3'd1,
    OP_RECT  = 3'd2,
    OP_FILL  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    LM_HORIZ,
    LM_VERT,
    LM_GEN
  } lmode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECT,
    S_LSET,
    S_MUL,
    S_DIVA,
    S_DIVB,
    S_RUN,
    S_NEXT,
    S_READ
  } state_t;

  typedef struct packed {
    coord_t w;
    coord_t h;
  } canvas_t;

  typedef struct packed {
    logic               en;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
  } pix_t;

  typedef struct packed {
    logic            en;
    logic            white;
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
  } rd_t;

endpackage
`default_nettype wire

>>> sv/framebuffer_line_rect_draw.sv
// Top level of the framebuffer line and rectangle drawing engine.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  opcode, coordinates, pen color
//   out_     output     out_valid/out_stall read color (read opcode only)
//   cfg_     input      cfg_wr_en          canvas width and height
//
// After reset the frame store is swept to white, one pixel per cycle; no
// item is taken during the sweep. One item is worked on at a time, and a
// plot is drawn as a line of one pixel. A read waits until the result
// register is free, then addresses the store; the color passes through the
// store's read register and then the result register.
// A horizontal or vertical line writes its clipped length in pixels, a
// sloped line first runs the multiply and the two serial divides, an outline
// is four such lines and a fill one line per visible row; the pixel write
// port takes one write a cycle.
// A read result waits in the output register under out_stall; drawing items
// are still taken, and a further read waits until that transfer completes.
`default_nettype none
module framebuffer_line_rect_draw #(
  parameter int MAX_WIDTH  = fblrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fblrd_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [2:0]                           in_opcode,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_coord_ax,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_coord_ay,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_coord_bx,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_coord_by,
  input  wire logic [fblrd_pkg::COLOR_W-1:0]        in_pen_color,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [fblrd_pkg::COLOR_W-1:0]             out_read_color,
  input  wire logic                                 cfg_wr_en,
  input  wire logic                                 cfg_index,
  input  wire logic [fblrd_pkg::CFG_W-1:0]          cfg_data
);
  localparam int CW = fblrd_pkg::CW;

  // Canvas registers; a size above the store's size acts as the store's size.
  logic [fblrd_pkg::CFG_W-1:0] cw_r, ch_r;
  fblrd_pkg::canvas_t          canvas;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= fblrd_pkg::CFG_W'(256);
      ch_r <= fblrd_pkg::CFG_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fblrd_pkg::CFG_CANVAS_W: cw_r <= cfg_data;
        default:                 ch_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    canvas.w = (CW'(cw_r) > CW'(MAX_WIDTH))  ? fblrd_pkg::coord_t'(CW'(MAX_WIDTH))
                                             : fblrd_pkg::coord_t'(CW'(cw_r));
    canvas.h = (CW'(ch_r) > CW'(MAX_HEIGHT)) ? fblrd_pkg::coord_t'(CW'(MAX_HEIGHT))
                                             : fblrd_pkg::coord_t'(CW'(ch_r));
  end

  // Output register; a read is issued only when this slot is free by the
  // next edge, so the returning data always finds it empty.
  logic                          out_valid_r, out_valid_nxt;
  logic [fblrd_pkg::COLOR_W-1:0] out_color_r;
  logic                          rd_pend_r, rd_white_r;
  logic                          out_free;
  logic                          idle, clearing, in_acc;
  fblrd_pkg::pix_t               pix;
  fblrd_pkg::rd_t                rd;
  logic [fblrd_pkg::COLOR_W-1:0] rd_data;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !idle || clearing;
  assign in_acc   = in_valid && !in_stall;

  fblrd_raster u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_opcode (in_opcode),
    .in_ax     (in_coord_ax),
    .in_ay     (in_coord_ay),
    .in_bx     (in_coord_bx),
    .in_by     (in_coord_by),
    .in_color  (in_pen_color),
    .canvas    (canvas),
    .out_free  (out_free),
    .idle      (idle),
    .pix       (pix),
    .rd        (rd)
  );

  fblrd_fb #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_fb (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (pix),
    .rd       (rd),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd.en;
    end
    rd_white_r <= rd.white;
    if (rd_pend_r) begin
      out_color_r <= rd_white_r ? fblrd_pkg::WHITE : rd_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_color = out_color_r;

endmodule
`default_nettype wire

>>> sv/fblrd_div.sv
// Bit-serial floor divider: signed numerator by a positive denominator.
`default_nettype none
module fblrd_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [fblrd_pkg::DIV_NW-1:0] num,
  input  wire logic [fblrd_pkg::DIV_DW-1:0]     den,
  output logic                                  done,
  output fblrd_pkg::coord_t                     quo,
  output logic [fblrd_pkg::DIV_DW-1:0]          rem
);
  localparam int NW = fblrd_pkg::DIV_NW;
  localparam int DW = fblrd_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NW-1:0]     a_r, a_nxt;
  logic [DW-1:0]     rm_r, rm_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic              neg_r, neg_nxt;
  logic [DW:0]       trial;
  logic [NW-1:0]     qneg;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    rm_nxt   = rm_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    trial    = {rm_r, a_r[NW-1]};
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        cnt_nxt  = CNT_W'(NW);
        a_nxt    = num[NW-1] ? NW'(-num) : NW'(num);
        rm_nxt   = '0;
        d_nxt    = den;
        neg_nxt  = num[NW-1];
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, d_r}) begin
        rm_nxt = DW'(trial - {1'b0, d_r});
        a_nxt  = {a_r[NW-2:0], 1'b1};
      end else begin
        rm_nxt = trial[DW-1:0];
        a_nxt  = {a_r[NW-2:0], 1'b0};
      end
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    rm_r  <= rm_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  // Floor correction of the magnitude result for a negative numerator.
  assign qneg = (rm_r == '0) ? NW'(-a_r) : ~a_r;
  assign done = busy_r && (cnt_r == '0);
  assign quo  = neg_r ? fblrd_pkg::coord_t'(qneg[fblrd_pkg::CW-1:0])
                      : fblrd_pkg::coord_t'(a_r[fblrd_pkg::CW-1:0]);
  assign rem  = (neg_r && rm_r != '0) ? DW'(d_r - rm_r) : rm_r;

endmodule
`default_nettype wire

>>> sv/fblrd_fb.sv
// Frame store memory with its clearing pass after reset.
`default_nettype none
module fblrd_fb #(
  parameter int MAX_WIDTH  = fblrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fblrd_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fblrd_pkg::pix_t                  pix,
  input  wire fblrd_pkg::rd_t                   rd,
  output logic [fblrd_pkg::COLOR_W-1:0]         rd_data,
  output logic                                  clearing
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [fblrd_pkg::COLOR_W-1:0] mem [DEPTH];
  logic                          clr_r, clr_nxt;
  logic [AW-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [fblrd_pkg::COLOR_W-1:0] rd_data_r;

  assign wr_addr = AW'(AW'(pix.y) * AW'(MAX_WIDTH) + AW'(pix.x));
  assign rd_addr = AW'(AW'(rd.y) * AW'(MAX_WIDTH) + AW'(rd.x));

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= fblrd_pkg::WHITE;
    end else if (pix.en) begin
      mem[wr_addr] <= pix.color;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule
`default_nettype wire

>>> sv/fblrd_raster.sv
// Command sequencer and line stepper that turn drawing items into pixel writes.
`default_nettype none
module fblrd_raster (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_acc,
  input  wire logic [2:0]                           in_opcode,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_ax,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_ay,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_bx,
  input  wire logic signed [fblrd_pkg::IN_W-1:0]    in_by,
  input  wire logic [fblrd_pkg::COLOR_W-1:0]        in_color,
  input  wire fblrd_pkg::canvas_t                   canvas,
  input  wire logic                                 out_free,
  output logic                                      idle,
  output fblrd_pkg::pix_t                           pix,
  output fblrd_pkg::rd_t                            rd
);
  localparam int CW = fblrd_pkg::CW;
  localparam int SW = fblrd_pkg::SL_W;
  localparam int DW = fblrd_pkg::DIV_DW;
  localparam int NW = fblrd_pkg::DIV_NW;
  localparam int XW = fblrd_pkg::XY_W;

  fblrd_pkg::state_t state_r, state_nxt;

  logic [2:0]                    op_r;
  fblrd_pkg::coord_t             ax_r, ay_r, bx_r, by_r;
  logic [fblrd_pkg::COLOR_W-1:0] col_r;
  fblrd_pkg::coord_t             lft_r, top_r, rgt_r, bot_r, row_r, rowhi_r;
  logic [1:0]                    seg_r;
  fblrd_pkg::coord_t             lx1_r, ly1_r, lx2_r, ly2_r;
  fblrd_pkg::lmode_t             mode_r;
  fblrd_pkg::coord_t             v_r, hi_r;
  logic signed [NW-1:0]          prod_r;
  logic signed [SW-1:0]          dys_r;
  logic [DW-1:0]                 d_r;
  fblrd_pkg::coord_t             q_r, qs_r;
  logic [DW-1:0]                 r_r, rs_r;
  logic                          pix_vld_r;
  fblrd_pkg::coord_t             pix_x_r, pix_y_r;

  // Segment setup.
  logic              horiz, vert;
  fblrd_pkg::coord_t la, lb, lmn, lmx, llim, llo, lhi, ldx, ldy, ldys, ldabs, ldlt;
  logic signed [SW-1:0] dlt_s;
  logic signed [NW-1:0] prod;

  assign horiz = (ly1_r == ly2_r);
  assign vert  = (lx1_r == lx2_r);

  always_comb begin
    la    = (vert && !horiz) ? ly1_r : lx1_r;
    lb    = (vert && !horiz) ? ly2_r : lx2_r;
    llim  = (vert && !horiz) ? canvas.h : canvas.w;
    lmn   = (la < lb) ? la : lb;
    lmx   = (la < lb) ? lb : la;
    llo   = (lmn < fblrd_pkg::C_ZERO) ? fblrd_pkg::C_ZERO : lmn;
    lhi   = (lmx > llim - fblrd_pkg::C_ONE) ? llim - fblrd_pkg::C_ONE : lmx;
    ldx   = lx2_r - lx1_r;
    ldy   = ly2_r - ly1_r;
    ldys  = (ldx < fblrd_pkg::C_ZERO) ? -ldy : ldy;
    ldabs = (ldx < fblrd_pkg::C_ZERO) ? -ldx : ldx;
    ldlt  = v_r - lx1_r;
  end

  assign dlt_s = ldlt[SW-1:0];
  assign prod  = dys_r * dlt_s;

  // Rectangle setup.
  fblrd_pkg::coord_t rl, rt, rr, rb, ylo, ybm, yhi;
  logic              rneg;

  always_comb begin
    rl   = ax_r - (bx_r >>> 1);
    rt   = ay_r - (by_r >>> 1);
    rr   = rl + bx_r;
    rb   = rt + by_r;
    ylo  = (rt < fblrd_pkg::C_ZERO) ? fblrd_pkg::C_ZERO : rt;
    ybm  = rb - fblrd_pkg::C_ONE;
    yhi  = (ybm > canvas.h - fblrd_pkg::C_ONE) ? canvas.h - fblrd_pkg::C_ONE : ybm;
    rneg = (bx_r < fblrd_pkg::C_ZERO) || (by_r < fblrd_pkg::C_ZERO);
  end

  // Incremental quotient of the general line.
  logic [DW:0]       rsum;
  logic              wrap;
  logic [DW-1:0]     r_step;
  fblrd_pkg::coord_t q_step, gen_y, step_x, step_y;

  always_comb begin
    rsum   = {1'b0, r_r} + {1'b0, rs_r};
    wrap   = (rsum >= {1'b0, d_r});
    r_step = wrap ? DW'(rsum - {1'b0, d_r}) : rsum[DW-1:0];
    q_step = q_r + qs_r + (wrap ? fblrd_pkg::C_ONE : fblrd_pkg::C_ZERO);
    gen_y  = ly1_r + q_r + ((q_r < fblrd_pkg::C_ZERO && r_r != '0) ?
                            fblrd_pkg::C_ONE : fblrd_pkg::C_ZERO);
    step_x = (mode_r == fblrd_pkg::LM_VERT) ? lx1_r : v_r;
    case (mode_r)
      fblrd_pkg::LM_HORIZ: step_y = ly1_r;
      fblrd_pkg::LM_VERT:  step_y = v_r;
      default:             step_y = gen_y;
    endcase
  end

  // Divider shared by the start offset and the per-step slope.
  logic                 div_start, div_done;
  logic signed [NW-1:0] div_num;
  fblrd_pkg::coord_t    div_q;
  logic [DW-1:0]        div_rem;

  fblrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fblrd_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode) inside
            fblrd_pkg::OP_PIXEL, fblrd_pkg::OP_LINE: state_nxt = fblrd_pkg::S_LSET;
            fblrd_pkg::OP_RECT, fblrd_pkg::OP_FILL:  state_nxt = fblrd_pkg::S_RECT;
            fblrd_pkg::OP_READ:                      state_nxt = fblrd_pkg::S_READ;
            default:                                 state_nxt = fblrd_pkg::S_IDLE;
          endcase
        end
      end
      fblrd_pkg::S_RECT: begin
        if (rneg || (op_r == fblrd_pkg::OP_FILL && ylo > yhi)) begin
          state_nxt = fblrd_pkg::S_IDLE;
        end else begin
          state_nxt = fblrd_pkg::S_LSET;
        end
      end
      fblrd_pkg::S_LSET: begin
        if (llo > lhi) begin
          state_nxt = fblrd_pkg::S_NEXT;
        end else if (horiz || vert) begin
          state_nxt = fblrd_pkg::S_RUN;
        end else begin
          state_nxt = fblrd_pkg::S_MUL;
        end
      end
      fblrd_pkg::S_MUL:  state_nxt = fblrd_pkg::S_DIVA;
      fblrd_pkg::S_DIVA: if (div_done) state_nxt = fblrd_pkg::S_DIVB;
      fblrd_pkg::S_DIVB: if (div_done) state_nxt = fblrd_pkg::S_RUN;
      fblrd_pkg::S_RUN:  if (v_r == hi_r) state_nxt = fblrd_pkg::S_NEXT;
      fblrd_pkg::S_NEXT: begin
        if ((op_r == fblrd_pkg::OP_RECT && seg_r != 2'd3) ||
            (op_r == fblrd_pkg::OP_FILL && row_r < rowhi_r)) begin
          state_nxt = fblrd_pkg::S_LSET;
        end else begin
          state_nxt = fblrd_pkg::S_IDLE;
        end
      end
      fblrd_pkg::S_READ: if (out_free) state_nxt = fblrd_pkg::S_IDLE;
      default:           state_nxt = fblrd_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  logic rd_in;

  always_comb begin
    idle      = (state_r == fblrd_pkg::S_IDLE);
    div_start = (state_r == fblrd_pkg::S_DIVA) || (state_r == fblrd_pkg::S_DIVB);
    div_num   = (state_r == fblrd_pkg::S_DIVB) ? NW'(dys_r) : prod_r;
    rd_in     = (ax_r >= fblrd_pkg::C_ZERO) && (ay_r >= fblrd_pkg::C_ZERO) &&
                (ax_r < canvas.w) && (ay_r < canvas.h);
    rd.en     = (state_r == fblrd_pkg::S_READ) && out_free;
    rd.white  = !rd_in;
    rd.x      = rd_in ? ax_r[XW-1:0] : '0;
    rd.y      = rd_in ? ay_r[XW-1:0] : '0;
    pix.en    = pix_vld_r && (pix_x_r >= fblrd_pkg::C_ZERO) &&
                (pix_y_r >= fblrd_pkg::C_ZERO) &&
                (pix_x_r < canvas.w) && (pix_y_r < canvas.h);
    pix.x     = pix_x_r[XW-1:0];
    pix.y     = pix_y_r[XW-1:0];
    pix.color = col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fblrd_pkg::S_IDLE;
      pix_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pix_vld_r <= (state_r == fblrd_pkg::S_RUN);
    end
  end

  always_ff @(posedge clk) begin
    pix_x_r <= step_x;
    pix_y_r <= step_y;
    unique case (state_r)
      fblrd_pkg::S_IDLE: begin
        if (in_acc) begin
          op_r  <= in_opcode;
          ax_r  <= CW'(in_ax);
          ay_r  <= CW'(in_ay);
          bx_r  <= CW'(in_bx);
          by_r  <= CW'(in_by);
          col_r <= in_color;
          lx1_r <= CW'(in_ax);
          ly1_r <= CW'(in_ay);
          if (in_opcode == fblrd_pkg::OP_LINE) begin
            lx2_r <= CW'(in_bx);
            ly2_r <= CW'(in_by);
          end else begin
            lx2_r <= CW'(in_ax);
            ly2_r <= CW'(in_ay);
          end
        end
      end
      fblrd_pkg::S_RECT: begin
        lft_r   <= rl;
        top_r   <= rt;
        rgt_r   <= rr;
        bot_r   <= rb;
        seg_r   <= 2'd0;
        row_r   <= ylo;
        rowhi_r <= yhi;
        if (op_r == fblrd_pkg::OP_FILL) begin
          lx1_r <= rl;
          ly1_r <= ylo;
          lx2_r <= rr;
          ly2_r <= ylo;
        end else begin
          lx1_r <= rl;
          ly1_r <= rt;
          lx2_r <= rl;
          ly2_r <= rb;
        end
      end
      fblrd_pkg::S_LSET: begin
        v_r  <= llo;
        hi_r <= lhi;
        if (horiz) begin
          mode_r <= fblrd_pkg::LM_HORIZ;
        end else if (vert) begin
          mode_r <= fblrd_pkg::LM_VERT;
        end else begin
          mode_r <= fblrd_pkg::LM_GEN;
        end
        dys_r <= ldys[SW-1:0];
        d_r   <= ldabs[DW-1:0];
      end
      fblrd_pkg::S_MUL: prod_r <= prod;
      fblrd_pkg::S_DIVA: begin
        if (div_done) begin
          q_r <= div_q;
          r_r <= div_rem;
        end
      end
      fblrd_pkg::S_DIVB: begin
        if (div_done) begin
          qs_r <= div_q;
          rs_r <= div_rem;
        end
      end
      fblrd_pkg::S_RUN: begin
        v_r <= v_r + fblrd_pkg::C_ONE;
        q_r <= q_step;
        r_r <= r_step;
      end
      fblrd_pkg::S_NEXT: begin
        if (op_r == fblrd_pkg::OP_FILL) begin
          row_r <= row_r + fblrd_pkg::C_ONE;
          lx1_r <= lft_r;
          ly1_r <= row_r + fblrd_pkg::C_ONE;
          lx2_r <= rgt_r;
          ly2_r <= row_r + fblrd_pkg::C_ONE;
        end else begin
          seg_r <= seg_r + 2'd1;
          case (seg_r)
            2'd0: begin
              lx1_r <= lft_r; ly1_r <= top_r; lx2_r <= rgt_r; ly2_r <= top_r;
            end
            2'd1: begin
              lx1_r <= rgt_r; ly1_r <= top_r; lx2_r <= rgt_r; ly2_r <= bot_r;
            end
            default: begin
              lx1_r <= lft_r; ly1_r <= bot_r; lx2_r <= rgt_r; ly2_r <= bot_r;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the framebuffer line and rectangle drawing engine.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int FB_W = 256;
  localparam int FB_H = 256;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [2:0]                           in_opcode = 3'd0;
  logic signed [fblrd_pkg::IN_W-1:0]    in_coord_ax = '0;
  logic signed [fblrd_pkg::IN_W-1:0]    in_coord_ay = '0;
  logic signed [fblrd_pkg::IN_W-1:0]    in_coord_bx = '0;
  logic signed [fblrd_pkg::IN_W-1:0]    in_coord_by = '0;
  logic [fblrd_pkg::COLOR_W-1:0]        in_pen_color = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [fblrd_pkg::COLOR_W-1:0]        out_read_color;
  logic                                 cfg_wr_en = 1'b0;
  logic                                 cfg_index = fblrd_pkg::CFG_CANVAS_W;
  logic [fblrd_pkg::CFG_W-1:0]          cfg_data = '0;

  framebuffer_line_rect_draw dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_coord_ax, .in_coord_ay,
    .in_coord_bx, .in_coord_by, .in_pen_color, .out_valid, .out_stall,
    .out_read_color, .cfg_wr_en, .cfg_index, .cfg_data
  );

  // The clock runs at an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the frame store and the canvas registers. It is updated
  // when an item transfer is accepted, so read results are predicted in order.
  logic [fblrd_pkg::COLOR_W-1:0] pixel_mem [FB_W*FB_H];
  int unsigned                   canvas_w;
  int unsigned                   canvas_h;
  logic [fblrd_pkg::COLOR_W-1:0] colors_due [$];
  int                            errors = 0;
  int                            burst_left = 0;
  bit                            hold_req = 1'b0;
  int                            hold_left = 0;
  int                            stall_mode = 0;
  int                            mode_left = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint act_w();
    return (canvas_w > FB_W) ? FB_W : longint'(canvas_w);
  endfunction

  function automatic longint act_h();
    return (canvas_h > FB_H) ? FB_H : longint'(canvas_h);
  endfunction

  function automatic bit on_canvas(input longint x, input longint y);
    return x >= 0 && y >= 0 && x < act_w() && y < act_h();
  endfunction

  task automatic paint_pixel(input longint x, input longint y, input logic [23:0] c);
    if (on_canvas(x, y)) pixel_mem[y*FB_W + x] = c;
  endtask

  // Lines are clipped to the canvas span first; sloped lines step along x and
  // take y from an exact quotient that truncates toward zero.
  task automatic paint_line(input longint x1, input longint y1, input longint x2,
                            input longint y2, input logic [23:0] c);
    longint lo, hi, v, a, b, lim;
    bit     horiz;
    if (y1 == y2 || x1 == x2) begin
      horiz = (y1 == y2);
      a   = horiz ? x1 : y1;
      b   = horiz ? x2 : y2;
      lim = horiz ? act_w() : act_h();
      lo  = (a < b) ? a : b;
      hi  = (a < b) ? b : a;
      if (lo < 0) lo = 0;
      if (hi > lim - 1) hi = lim - 1;
      for (v = lo; v <= hi; v++) begin
        if (horiz) paint_pixel(v, y1, c);
        else paint_pixel(x1, v, c);
      end
    end else begin
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      if (lo < 0) lo = 0;
      if (hi > act_w() - 1) hi = act_w() - 1;
      for (v = lo; v <= hi; v++) paint_pixel(v, y1 + ((y2 - y1) * (v - x1)) / (x2 - x1), c);
    end
  endtask

  task automatic predict_item(input logic [2:0] op, input logic signed [15:0] sax,
                              input logic signed [15:0] say, input logic signed [15:0] sbx,
                              input logic signed [15:0] sby, input logic [23:0] c);
    longint ax, ay, bx, by, left, top, r, r0, r1;
    ax = longint'(sax);
    ay = longint'(say);
    bx = longint'(sbx);
    by = longint'(sby);
    case (op)
      fblrd_pkg::OP_PIXEL: paint_pixel(ax, ay, c);
      fblrd_pkg::OP_LINE:  paint_line(ax, ay, bx, by, c);
      fblrd_pkg::OP_RECT, fblrd_pkg::OP_FILL: begin
        // A negative size draws nothing, so the halves below are of
        // non-negative sizes.
        if (bx >= 0 && by >= 0) begin
          left = ax - bx / 2;
          top  = ay - by / 2;
          if (op == fblrd_pkg::OP_RECT) begin
            paint_line(left, top, left, top + by, c);
            paint_line(left, top, left + bx, top, c);
            paint_line(left + bx, top, left + bx, top + by, c);
            paint_line(left, top + by, left + bx, top + by, c);
          end else begin
            r0 = 0;
            r1 = by - 1;
            if (top + r0 < 0) r0 = -top;
            if (top + r1 > act_h() - 1) r1 = act_h() - 1 - top;
            for (r = r0; r <= r1; r++) paint_line(left, top + r, left + bx, top + r, c);
          end
        end
      end
      fblrd_pkg::OP_READ:
        colors_due.push_back(on_canvas(ax, ay) ? pixel_mem[ay*FB_W + ax] : fblrd_pkg::WHITE);
      default: ;
    endcase
  endtask

  // Offers one item and waits for its transfer. The sender works in bursts:
  // valid stays high into the next call until the burst runs out, then a gap.
  task automatic send_item(input logic [2:0] op, input int ax, input int ay,
                           input int bx, input int by, input logic [23:0] c);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_coord_ax  <= 16'(ax);
    in_coord_ay  <= 16'(ay);
    in_coord_bx  <= 16'(bx);
    in_coord_by  <= 16'(by);
    in_pen_color <= c;
    do @(posedge clk); while (in_stall);
    predict_item(op, 16'(ax), 16'(ay), 16'(bx), 16'(by), c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // A read at the end proves every earlier drawing item has finished, since
  // the engine works on one item at a time; then the sender waits for it.
  task automatic drain();
    send_item(fblrd_pkg::OP_READ, 0, 0, 0, 0, 24'h0);
    in_valid <= 1'b0;
    while (colors_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_canvas(input int unsigned w, input int unsigned h);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= fblrd_pkg::CFG_CANVAS_W;
    cfg_data  <= w[fblrd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= fblrd_pkg::CFG_CANVAS_H;
    cfg_data  <= h[fblrd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    canvas_w = w & 32'h1FF;
    canvas_h = h & 32'h1FF;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300) - 20);
  endfunction

  function automatic logic [15:0] rand_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 90) return 16'($urandom_range(0, 26) - 2);
    if (pick < 98) return 16'($urandom_range(0, 300));
    return 16'($urandom);
  endfunction

  task automatic random_item();
    logic [2:0]  op;
    logic [15:0] bx, by;
    op = ($urandom_range(0, 3) == 0) ? fblrd_pkg::OP_READ : 3'($urandom_range(0, 7));
    if (op == fblrd_pkg::OP_RECT || op == fblrd_pkg::OP_FILL) begin
      bx = rand_size();
      by = rand_size();
      // Huge fills take a whole canvas each; keep them rare.
      if (op == fblrd_pkg::OP_FILL && !bx[15] && !by[15] && bx > 300 && by > 300 &&
          $urandom_range(0, 3) != 0) by = 16'd5;
    end else begin
      bx = rand_coord();
      by = rand_coord();
    end
    send_item(op, int'(rand_coord()), int'(rand_coord()), int'(bx), int'(by),
              24'($urandom));
  endtask

  task automatic test_directed();
    send_item(fblrd_pkg::OP_READ, 0, 0, 0, 0, 24'h0);
    send_item(fblrd_pkg::OP_PIXEL, 0, 0, 0, 0, 24'h000000);
    send_item(fblrd_pkg::OP_PIXEL, 255, 255, 0, 0, 24'hFFFFFF);
    send_item(fblrd_pkg::OP_PIXEL, 255, 0, 0, 0, 24'h123456);
    send_item(fblrd_pkg::OP_PIXEL, -1, 0, 0, 0, 24'hABCDEF);
    send_item(fblrd_pkg::OP_PIXEL, 256, 3, 0, 0, 24'hABCDEF);
    send_item(fblrd_pkg::OP_PIXEL, -32768, 32767, 0, 0, 24'h555555);
    send_item(fblrd_pkg::OP_READ, 0, 0, 0, 0, 24'h0);
    send_item(fblrd_pkg::OP_READ, 255, 0, 0, 0, 24'h0);
    send_item(fblrd_pkg::OP_READ, -32768, 32767, 0, 0, 24'h0);
    send_item(fblrd_pkg::OP_LINE, -32768, 10, 32767, 10, 24'hFF0000);
    send_item(fblrd_pkg::OP_LINE, 20, 32767, 20, -32768, 24'h00FF00);
    send_item(fblrd_pkg::OP_LINE, 250, 3, 2, 200, 24'h0000FF);
    send_item(fblrd_pkg::OP_LINE, 5, 5, 9, -100, 24'hAAAAAA);
    send_item(fblrd_pkg::OP_RECT, 100, 100, 21, 10, 24'h00FFFF);
    send_item(fblrd_pkg::OP_RECT, 100, 100, -1, 10, 24'h111111);
    send_item(fblrd_pkg::OP_FILL, 40, 60, 7, 6, 24'hFF00FF);
    send_item(fblrd_pkg::OP_FILL, 40, 60, 7, 0, 24'h222222);
    send_item(fblrd_pkg::OP_FILL, 0, 0, 3, -32768, 24'h333333);
    send_item(3'd5, 1, 1, 1, 1, 24'h444444);
    send_item(3'd6, 1, 1, 1, 1, 24'h444444);
    send_item(3'd7, 1, 1, 1, 1, 24'h444444);
    send_item(fblrd_pkg::OP_READ, 20, 10, 0, 0, 24'h0);
    send_item(fblrd_pkg::OP_READ, 40, 58, 0, 0, 24'h0);
    drain();
  endtask

  task automatic test_random_canvases();
    int unsigned widths [7]  = '{256, 1, 0, 511, 37, 256, 100};
    int unsigned heights [7] = '{256, 1, 5, 300, 200, 1, 100};
    for (int p = 0; p < 7; p++) begin
      write_canvas(widths[p], heights[p]);
      repeat (140) random_item();
    end
    write_canvas(256, 256);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // result register stays full and a later read stalls the input.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (40) random_item();
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 3000;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Every result transfer is checked against the oldest predicted color.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        report($sformatf("unexpected result %h", out_read_color));
      end else begin
        if (out_read_color !== colors_due[0])
          report($sformatf("read_color %h, predicted %h", out_read_color, colors_due[0]));
        void'(colors_due.pop_front());
      end
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < FB_W*FB_H; i++) pixel_mem[i] = fblrd_pkg::WHITE;
    canvas_w = 256;
    canvas_h = 256;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_backpressure();
    test_random_canvases();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && colors_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
